// ===== rtl/core/mas_pkg.sv =====
// Shared types, constants and helper functions of the matrix add, subtract and multiply unit.
package mas_pkg;

   // Largest supported matrix dimension and depth of each element store.
   localparam int MAX_DIM     = 8;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = 4;
   localparam int CNT_W       = ADDR_W + 1;
   localparam int DATA_W      = 32;

   // Operation codes of the op_mode register.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE = 3'd4;

   // One request: an element for matrix A or matrix B.
   typedef struct packed {
      logic                     to_matrix_b;
      logic signed [DATA_W-1:0] element;
   } req_type;

   // One result element, or the single error result.
   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [IDX_W-1:0]         result_row;
      logic [IDX_W-1:0]         result_col;
      logic                     last;
      logic                     dim_error;
   } rsp_type;

   // Write into one of the two element stores.
   typedef struct packed {
      logic              en;
      logic              sel_b;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   // Run description handed from the loader to the compute engine.
   typedef struct packed {
      logic             fit;
      logic             mul;
      logic             sub;
      logic [DIM_W-1:0] rr;
      logic [DIM_W-1:0] rc;
      logic [DIM_W-1:0] kn;
      logic [DIM_W-1:0] ca;
      logic [DIM_W-1:0] cb;
   } run_cfg_type;

   // Tag that travels with a read through the compute pipeline.
   typedef struct packed {
      logic             valid;
      logic             first_k;
      logic             last_k;
      logic             last_all;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } pipe_tag_type;

   // Compute engine states.
   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_RUN,
      ENG_DRAIN,
      ENG_ERR
   } eng_state_type;

   // A dimension register of zero counts as one, anything above the maximum as the maximum.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/mas_store.sv =====
// Element stores for matrix A and matrix B, one write port and registered reads.
module mas_store (
   input  logic                            clock,
   input  mas_pkg::store_wr_type           wr,
   input  logic [mas_pkg::ADDR_W-1:0]      rd_addr_a,
   input  logic [mas_pkg::ADDR_W-1:0]      rd_addr_b,
   output logic [mas_pkg::DATA_W-1:0]      rd_data_a,
   output logic [mas_pkg::DATA_W-1:0]      rd_data_b
);

   logic [mas_pkg::DATA_W-1:0] mem_a [mas_pkg::STORE_DEPTH];
   logic [mas_pkg::DATA_W-1:0] mem_b [mas_pkg::STORE_DEPTH];

   // Matrix A store: write when selected, read every cycle.
   always_ff @(posedge clock) begin
      if (wr.en && !wr.sel_b) begin
         mem_a[wr.addr] <= wr.data;
      end
      rd_data_a <= mem_a[rd_addr_a];
   end

   // Matrix B store: write when selected, read every cycle.
   always_ff @(posedge clock) begin
      if (wr.en && wr.sel_b) begin
         mem_b[wr.addr] <= wr.data;
      end
      rd_data_b <= mem_b[rd_addr_b];
   end

endmodule

// ===== rtl/core/mas_engine.sv =====
// Compute engine: walks the result matrix, reads both stores and emits result elements.
module mas_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          launch,
   input  mas_pkg::run_cfg_type          run_cfg,
   output logic [mas_pkg::ADDR_W-1:0]    rd_addr_a,
   output logic [mas_pkg::ADDR_W-1:0]    rd_addr_b,
   input  logic [mas_pkg::DATA_W-1:0]    rd_data_a,
   input  logic [mas_pkg::DATA_W-1:0]    rd_data_b,
   output logic                          done,
   output logic                          rsp_valid,
   output mas_pkg::rsp_type              rsp_data
);

   mas_pkg::eng_state_type state_ff, state_in;
   mas_pkg::run_cfg_type   cfg_ff, cfg_in;
   logic [mas_pkg::IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   mas_pkg::pipe_tag_type  p1_ff, p1_in, p2_ff, p2_in;
   logic [mas_pkg::DATA_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mas_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic k_last, j_last, i_last, issue;
   logic [mas_pkg::CNT_W-1:0] a_addr_full, b_addr_full;
   logic [mas_pkg::DATA_W-1:0] sum;

   // Sequencer, address generation and the three pipeline stages.
   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      p1_in        = '0;
      p2_in        = p1_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      done         = 1'b0;
      issue        = (state_ff == mas_pkg::ENG_RUN);

      k_last = ({1'b0, k_ff} + mas_pkg::DIM_W'(1)) == cfg_ff.kn;
      j_last = ({1'b0, j_ff} + mas_pkg::DIM_W'(1)) == cfg_ff.rc;
      i_last = ({1'b0, i_ff} + mas_pkg::DIM_W'(1)) == cfg_ff.rr;

      // Row-major addresses; the inner index is k for a product, j otherwise.
      if (cfg_ff.mul) begin
         a_addr_full = mas_pkg::CNT_W'(i_ff) * mas_pkg::CNT_W'(cfg_ff.ca)
                       + mas_pkg::CNT_W'(k_ff);
         b_addr_full = mas_pkg::CNT_W'(k_ff) * mas_pkg::CNT_W'(cfg_ff.cb)
                       + mas_pkg::CNT_W'(j_ff);
      end else begin
         a_addr_full = mas_pkg::CNT_W'(i_ff) * mas_pkg::CNT_W'(cfg_ff.ca)
                       + mas_pkg::CNT_W'(j_ff);
         b_addr_full = mas_pkg::CNT_W'(i_ff) * mas_pkg::CNT_W'(cfg_ff.cb)
                       + mas_pkg::CNT_W'(j_ff);
      end
      rd_addr_a = a_addr_full[mas_pkg::ADDR_W-1:0];
      rd_addr_b = b_addr_full[mas_pkg::ADDR_W-1:0];

      // Issue stage: one read pair per cycle, counters step k, then j, then i.
      if (issue) begin
         p1_in.valid    = 1'b1;
         p1_in.first_k  = (k_ff == '0);
         p1_in.last_k   = k_last;
         p1_in.last_all = i_last && j_last;
         p1_in.row      = i_ff;
         p1_in.col      = j_ff;
         if (!k_last) begin
            k_in = k_ff + 1'b1;
         end else begin
            k_in = '0;
            if (!j_last) begin
               j_in = j_ff + 1'b1;
            end else begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end
         end
      end

      // Operate stage: read data is valid in the cycle after the address.
      if (p1_ff.valid) begin
         if (cfg_ff.mul) begin
            prod_in = rd_data_a * rd_data_b;
         end else if (cfg_ff.sub) begin
            prod_in = rd_data_a - rd_data_b;
         end else begin
            prod_in = rd_data_a + rd_data_b;
         end
      end

      // Accumulate stage: each dot product starts from zero.
      sum = (p2_ff.first_k ? '0 : acc_ff) + prod_ff;
      if (p2_ff.valid) begin
         acc_in = sum;
         if (p2_ff.last_k) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_value = sum;
            rsp_data_in.result_row   = p2_ff.row;
            rsp_data_in.result_col   = p2_ff.col;
            rsp_data_in.last         = p2_ff.last_all;
            rsp_data_in.dim_error    = 1'b0;
            done                     = p2_ff.last_all;
         end
      end

      unique case (state_ff)
         mas_pkg::ENG_IDLE: begin
            if (launch) begin
               cfg_in   = run_cfg;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = run_cfg.fit ? mas_pkg::ENG_RUN : mas_pkg::ENG_ERR;
            end
         end
         mas_pkg::ENG_RUN: begin
            if (k_last && j_last && i_last) begin
               state_in = mas_pkg::ENG_DRAIN;
            end
         end
         mas_pkg::ENG_DRAIN: begin
            if (done) begin
               state_in = mas_pkg::ENG_IDLE;
            end
         end
         mas_pkg::ENG_ERR: begin
            // Dimensions do not fit: one zero result that carries the error mark.
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{result_value: '0, result_row: '0, result_col: '0,
                             last: 1'b1, dim_error: 1'b1};
            done         = 1'b1;
            state_in     = mas_pkg::ENG_IDLE;
         end
         default: begin
            state_in = mas_pkg::ENG_IDLE;
         end
      endcase
   end

   // Control registers and pipeline tags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mas_pkg::ENG_IDLE;
         p1_ff        <= '0;
         p2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cfg_ff           <= cfg_in;
      i_ff             <= i_in;
      j_ff             <= j_in;
      k_ff             <= k_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      rsp_data_ff      <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/matrix_add_sub_multiply_unit.sv =====
// Top level of the matrix add, subtract and multiply unit: configuration, loader and run launch.
//
// Usage:
//   Configuration registers (rows_a, cols_a, rows_b, cols_b, op_mode) are written on the
//   csr_ channel while the unit is idle; csr_ready is always high.
//   A request is taken at a rising edge with start high and busy low. It carries one
//   element for matrix A or matrix B; elements fill each store in row-major order and
//   elements beyond a matrix's size are dropped. A request that completes neither
//   matrix leaves busy low, so the next request can be taken in the following cycle.
//   When the request that completes both matrices is taken, busy rises and the run
//   starts. A dimension mismatch yields one error result from the ERR state through the
//   result register. Otherwise each result passes the store read, the product register
//   and the result register; add and subtract give one result per read pair, multiply
//   one per cols_a pairs. The engine issues one read pair of the two stores per cycle,
//   rows * cols * (cols_a for multiply, else 1) pairs in a run. busy falls as the final
//   result is shown. Each result is on rsp_data for exactly one cycle with rsp_valid high;
//   the receiver cannot stall it. Reset clears the load counts, the registers to their
//   defaults (dimensions 1, add) and the engine; store contents stay as they were.
module matrix_add_sub_multiply_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mas_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output mas_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mas_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [mas_pkg::DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [1:0]                op_mode_ff;
   logic [mas_pkg::CNT_W-1:0] loaded_a_ff, loaded_a_in, loaded_b_ff, loaded_b_in;
   logic                      busy_ff, busy_in;

   logic [mas_pkg::DIM_W-1:0] ra, ca, rb, cb;
   logic [mas_pkg::CNT_W-1:0] size_a, size_b, next_a, next_b;
   logic                      accept, launch, eng_done;
   mas_pkg::run_cfg_type      run_cfg;
   mas_pkg::store_wr_type     store_wr;
   logic [mas_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [mas_pkg::DATA_W-1:0] rd_data_a, rd_data_b;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff  <= mas_pkg::DIM_W'(1);
         cols_a_ff  <= mas_pkg::DIM_W'(1);
         rows_b_ff  <= mas_pkg::DIM_W'(1);
         cols_b_ff  <= mas_pkg::DIM_W'(1);
         op_mode_ff <= mas_pkg::OP_ADD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mas_pkg::CSR_ROWS_A:  rows_a_ff  <= csr_wdata;
            mas_pkg::CSR_COLS_A:  cols_a_ff  <= csr_wdata;
            mas_pkg::CSR_ROWS_B:  rows_b_ff  <= csr_wdata;
            mas_pkg::CSR_COLS_B:  cols_b_ff  <= csr_wdata;
            mas_pkg::CSR_OP_MODE: op_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Effective dimensions, matrix sizes and the fit check for the selected operation.
   always_comb begin
      ra     = mas_pkg::eff_dim(rows_a_ff);
      ca     = mas_pkg::eff_dim(cols_a_ff);
      rb     = mas_pkg::eff_dim(rows_b_ff);
      cb     = mas_pkg::eff_dim(cols_b_ff);
      size_a = mas_pkg::CNT_W'(ra) * mas_pkg::CNT_W'(ca);
      size_b = mas_pkg::CNT_W'(rb) * mas_pkg::CNT_W'(cb);

      run_cfg     = '0;
      run_cfg.ca  = ca;
      run_cfg.cb  = cb;
      run_cfg.rr  = ra;
      run_cfg.kn  = mas_pkg::DIM_W'(1);
      unique case (op_mode_ff) inside
         mas_pkg::OP_ADD, mas_pkg::OP_SUB: begin
            run_cfg.fit = (ra == rb) && (ca == cb);
            run_cfg.sub = (op_mode_ff == mas_pkg::OP_SUB);
            run_cfg.rc  = ca;
         end
         mas_pkg::OP_MUL: begin
            run_cfg.fit = (ca == rb);
            run_cfg.mul = 1'b1;
            run_cfg.rc  = cb;
            run_cfg.kn  = ca;
         end
         default: begin
            run_cfg.fit = 1'b0;
         end
      endcase
   end

   // Loader: store the element if its matrix has room, launch when both are complete.
   always_comb begin
      next_a         = loaded_a_ff;
      next_b         = loaded_b_ff;
      store_wr       = '0;
      store_wr.sel_b = req_data.to_matrix_b;
      store_wr.data  = req_data.element;
      store_wr.addr  = req_data.to_matrix_b ? loaded_b_ff[mas_pkg::ADDR_W-1:0]
                                            : loaded_a_ff[mas_pkg::ADDR_W-1:0];
      if (accept) begin
         if (!req_data.to_matrix_b && (loaded_a_ff < size_a)) begin
            store_wr.en = 1'b1;
            next_a      = loaded_a_ff + 1'b1;
         end
         if (req_data.to_matrix_b && (loaded_b_ff < size_b)) begin
            store_wr.en = 1'b1;
            next_b      = loaded_b_ff + 1'b1;
         end
      end
      launch      = accept && (next_a >= size_a) && (next_b >= size_b);
      loaded_a_in = launch ? '0 : next_a;
      loaded_b_in = launch ? '0 : next_b;
      busy_in     = launch ? 1'b1 : (eng_done ? 1'b0 : busy_ff);
   end

   // Load counts and busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_a_ff <= '0;
         loaded_b_ff <= '0;
         busy_ff     <= 1'b0;
      end else begin
         loaded_a_ff <= loaded_a_in;
         loaded_b_ff <= loaded_b_in;
         busy_ff     <= busy_in;
      end
   end

   mas_store u_store (
      .clock     (clock),
      .wr        (store_wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mas_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .launch    (launch),
      .run_cfg   (run_cfg),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .done      (eng_done),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/mas_checker.sv =====
// Port-level checks of the matrix add, subtract and multiply unit, bound to the top level.
module mas_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input mas_pkg::rsp_type               rsp_data
);

   // Results before the final one belong to a run that still holds busy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> busy)
      else $error("non-final result while not busy");

   // The error result is a single zero result at position zero that ends the run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dim_error) |->
         (rsp_data.last && rsp_data.result_value == 0 &&
          rsp_data.result_row == 0 && rsp_data.result_col == 0))
      else $error("malformed error result");

   // Nothing follows the final result of a run in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("result right after the final one");

   // A request taken while idle never yields a result in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result one cycle after a request");

endmodule

bind matrix_add_sub_multiply_unit mas_checker u_mas_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_matrix_add_sub_multiply_unit.sv =====
// Self-checking testbench of the matrix add, subtract and multiply unit.
`timescale 1ns / 1ps

module tb_matrix_add_sub_multiply_unit;
   import mas_pkg::*;

   localparam int         ITEM_TARGET   = 160;
   localparam int         IDLE_PCT      = 29;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         CYCLE_LIMIT   = 400000;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Requests waiting to be driven and results the unit still owes.
   req_type element_queue[$];
   rsp_type awaited_results[$];
   rsp_type want_rsp;
   bit      steady_send;

   // Mirror of the unit: element stores, load counts and registers.
   logic [DATA_W-1:0]     mat_a[STORE_DEPTH];
   logic [DATA_W-1:0]     mat_b[STORE_DEPTH];
   int                    fill_a;
   int                    fill_b;
   logic [CSR_DATA_W-1:0] shape_rows_a;
   logic [CSR_DATA_W-1:0] shape_cols_a;
   logic [CSR_DATA_W-1:0] shape_rows_b;
   logic [CSR_DATA_W-1:0] shape_cols_b;
   logic [1:0]            shape_op;

   // Run statistics.
   int mismatch_count;
   int accepted_count;
   int dropped_count;
   int run_count;
   int error_run_count;
   int checked_count;
   int shape_count;
   int queued_count;
   int cycle_count;

   matrix_add_sub_multiply_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // A dimension register of zero acts as one, anything above the maximum as the maximum.
   function automatic int active_dim(input logic [CSR_DATA_W-1:0] v);
      int d;
      d = int'(v);
      if (d < 1) begin
         d = 1;
      end else if (d > MAX_DIM) begin
         d = MAX_DIM;
      end
      return d;
   endfunction

   // Takes one element into the mirror and, once both matrices are full, queues the run's results.
   function automatic void absorb_element(input req_type r);
      int                ra, ca, rb, cb, rr, rc;
      bit                fits;
      logic [DATA_W-1:0] acc;
      rsp_type           res;
      ra = active_dim(shape_rows_a);
      ca = active_dim(shape_cols_a);
      rb = active_dim(shape_rows_b);
      cb = active_dim(shape_cols_b);
      if (!r.to_matrix_b) begin
         if (fill_a < ra * ca) begin
            mat_a[fill_a] = r.element;
            fill_a++;
         end
      end else begin
         if (fill_b < rb * cb) begin
            mat_b[fill_b] = r.element;
            fill_b++;
         end
      end
      if (fill_a >= ra * ca && fill_b >= rb * cb) begin
         fill_a = 0;
         fill_b = 0;
         run_count++;
         rr = ra;
         rc = ca;
         case (shape_op)
            OP_ADD, OP_SUB: begin
               fits = (ra == rb) && (ca == cb);
            end
            OP_MUL: begin
               fits = (ca == rb);
               rc = cb;
            end
            default: begin
               fits = 1'b0;
            end
         endcase
         if (!fits) begin
            error_run_count++;
            res = '0;
            res.last = 1'b1;
            res.dim_error = 1'b1;
            awaited_results.push_back(res);
         end else begin
            for (int i = 0; i < rr; i++) begin
               for (int j = 0; j < rc; j++) begin
                  if (shape_op == OP_MUL) begin
                     acc = '0;
                     for (int k = 0; k < ca; k++) begin
                        acc = acc + mat_a[i * ca + k] * mat_b[k * cb + j];
                     end
                  end else if (shape_op == OP_SUB) begin
                     acc = mat_a[i * ca + j] - mat_b[i * cb + j];
                  end else begin
                     acc = mat_a[i * ca + j] + mat_b[i * cb + j];
                  end
                  res.result_value = acc;
                  res.result_row = IDX_W'(i);
                  res.result_col = IDX_W'(j);
                  res.last = (i == rr - 1) && (j == rc - 1);
                  res.dim_error = 1'b0;
                  awaited_results.push_back(res);
               end
            end
         end
      end
   endfunction

   // Request driver: holds a request until it is taken, then idles at random or sends the next.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // The current request is still waiting to be taken.
      end else begin
         if (start) begin
            absorb_element(req_data);
            accepted_count++;
         end
         if (element_queue.size() != 0 &&
             (steady_send || $urandom_range(99) >= IDLE_PCT)) begin
            start <= 1'b1;
            req_data <= element_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result monitor: every strobed result is compared with the oldest awaited one.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: result with nothing awaited, expected none, actual %p", $time,
                     rsp_data);
            mismatch_count++;
         end else begin
            want_rsp = awaited_results.pop_front();
            check_field("result_value", want_rsp.result_value, rsp_data.result_value);
            check_field("result_row", DATA_W'(want_rsp.result_row), DATA_W'(rsp_data.result_row));
            check_field("result_col", DATA_W'(want_rsp.result_col), DATA_W'(rsp_data.result_col));
            check_field("last", DATA_W'(want_rsp.last), DATA_W'(rsp_data.last));
            check_field("dim_error", DATA_W'(want_rsp.dim_error), DATA_W'(rsp_data.dim_error));
            checked_count++;
         end
      end
   end

   // Waits until every request is taken, every result has come and the unit has gone idle.
   task automatic wait_quiet();
      do begin
         @(negedge clock);
      end while (element_queue.size() != 0 || start || awaited_results.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write on the configuration channel; the mirror follows on acceptance.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ROWS_A:  shape_rows_a = val;
         CSR_COLS_A:  shape_cols_a = val;
         CSR_ROWS_B:  shape_rows_b = val;
         CSR_COLS_B:  shape_cols_b = val;
         CSR_OP_MODE: shape_op = val[1:0];
         default: ;
      endcase
   endtask

   // Drains the unit and then programs all five registers with raw values.
   task automatic set_shape(input logic [CSR_DATA_W-1:0] ra, input logic [CSR_DATA_W-1:0] ca,
                            input logic [CSR_DATA_W-1:0] rb, input logic [CSR_DATA_W-1:0] cb,
                            input logic [1:0] op);
      wait_quiet();
      write_csr(CSR_ROWS_A, ra);
      write_csr(CSR_COLS_A, ca);
      write_csr(CSR_ROWS_B, rb);
      write_csr(CSR_COLS_B, cb);
      write_csr(CSR_OP_MODE, {2'($urandom_range(3)), op});
      shape_count++;
   endtask

   // Queues one request and counts it toward the total sent.
   function automatic void push_item(input bit to_b, input logic [DATA_W-1:0] v);
      req_type item;
      item.to_matrix_b = to_b;
      item.element = v;
      element_queue.push_back(item);
      queued_count++;
   endfunction

   // Element values lean toward the wrap-around extremes.
   function automatic logic [DATA_W-1:0] draw_element();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         4: return 32'($urandom_range(32)) - 32'd16;
         default: return $urandom;
      endcase
   endfunction

   // Queues one complete run in random interleaving; once one matrix is full, some
   // further elements for it are sent and must be dropped.
   function automatic void queue_run(input int size_a, input int size_b, input int noise_pct);
      int na, nb;
      na = 0;
      nb = 0;
      while (na < size_a || nb < size_b) begin
         if (na == size_a) begin
            if ($urandom_range(99) < noise_pct) begin
               push_item(1'b0, draw_element());
               dropped_count++;
            end else begin
               push_item(1'b1, draw_element());
               nb++;
            end
         end else if (nb == size_b) begin
            if ($urandom_range(99) < noise_pct) begin
               push_item(1'b1, draw_element());
               dropped_count++;
            end else begin
               push_item(1'b0, draw_element());
               na++;
            end
         end else if ($urandom_range(1) == 1) begin
            push_item(1'b1, draw_element());
            nb++;
         end else begin
            push_item(1'b0, draw_element());
            na++;
         end
      end
   endfunction

   // A dimension of one is sometimes written as zero, and of eight as a value above eight.
   function automatic logic [CSR_DATA_W-1:0] encode_dim(input int d);
      if (d == 1 && $urandom_range(99) < 30) begin
         return '0;
      end else if (d == MAX_DIM && $urandom_range(1) == 1) begin
         return CSR_DATA_W'($urandom_range(15, MAX_DIM + 1));
      end
      return CSR_DATA_W'(d);
   endfunction

   // Timeout guard.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_matrix_add_sub_multiply_unit failed");
      $finish;
   end

   // Stimulus sequence.
   initial begin
      int         ra, ca, rb, cb, runs, pick;
      logic [1:0] op;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      steady_send = 1'b0;
      cycle_count = 0;
      fill_a = 0;
      fill_b = 0;
      shape_rows_a = 4'd1;
      shape_cols_a = 4'd1;
      shape_rows_b = 4'd1;
      shape_cols_b = 4'd1;
      shape_op = OP_ADD;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset shape, one by one add: positive wrap, and an extra A element that is dropped.
      push_item(1'b0, 32'h7fff_ffff);
      push_item(1'b0, 32'h0000_0005);
      push_item(1'b1, 32'h0000_0001);
      dropped_count++;

      // Subtract with negative wrap, B loaded before A.
      set_shape(4'd1, 4'd1, 4'd1, 4'd1, OP_SUB);
      push_item(1'b1, 32'h0000_0001);
      push_item(1'b0, 32'h8000_0000);

      // Multiply one by two times two by two, rows of A written as zero; one B extra dropped.
      set_shape(4'd0, 4'd2, 4'd2, 4'd2, OP_MUL);
      push_item(1'b0, 32'hffff_ffff);
      push_item(1'b1, 32'h8000_0000);
      push_item(1'b1, 32'h7fff_ffff);
      push_item(1'b1, 32'hffff_ffff);
      push_item(1'b1, 32'h0000_0001);
      push_item(1'b1, 32'h1234_5678);
      push_item(1'b0, 32'h8000_0000);
      dropped_count++;

      // The unused operation code always gives the error result.
      set_shape(4'd1, 4'd1, 4'd1, 4'd1, OP_UNUSED);
      push_item(1'b0, 32'h0000_0001);
      push_item(1'b1, 32'h0000_0002);

      // Add with differing shapes.
      set_shape(4'd1, 4'd1, 4'd2, 4'd1, OP_ADD);
      push_item(1'b0, 32'h0000_0003);
      push_item(1'b1, 32'h0000_0004);
      push_item(1'b1, 32'h0000_0005);

      // Multiply whose inner dimensions differ.
      set_shape(4'd1, 4'd2, 4'd1, 4'd1, OP_MUL);
      push_item(1'b0, 32'h0000_0006);
      push_item(1'b0, 32'h0000_0007);
      push_item(1'b1, 32'h0000_0008);

      // Writes to indexes above op_mode must leave the registers alone.
      set_shape(4'd1, 4'd1, 4'd1, 4'd1, OP_ADD);
      write_csr(CSR_OP_MODE + 3'd1, 4'hf);
      write_csr(CSR_OP_MODE + 3'd2, 4'h2);
      write_csr(CSR_OP_MODE + 3'd3, 4'h0);
      push_item(1'b0, 32'h0000_0000);
      push_item(1'b1, 32'h0000_0000);

      // Eight by one times one by eight: the largest result matrix.
      set_shape(4'd8, 4'd0, 4'd0, 4'd15, OP_MUL);
      queue_run(8, 8, 15);

      // Full eight by eight A times eight by one B, sent without any gaps.
      set_shape(4'd8, 4'd12, 4'd8, 4'd1, OP_MUL);
      steady_send = 1'b1;
      queue_run(64, 8, 0);
      wait_quiet();
      steady_send = 1'b0;

      // Random shapes, mostly fitting, each phase carrying a few runs.
      while (queued_count < ITEM_TARGET) begin
         pick = $urandom_range(99);
         op = (pick < 30) ? OP_ADD : (pick < 55) ? OP_SUB : (pick < 92) ? OP_MUL : OP_UNUSED;
         ra = ($urandom_range(11) == 0) ? MAX_DIM : $urandom_range(1, 3);
         ca = ($urandom_range(11) == 0) ? MAX_DIM : $urandom_range(1, 3);
         rb = $urandom_range(1, 3);
         cb = $urandom_range(1, 3);
         if ($urandom_range(99) < 80) begin
            if (op == OP_MUL) begin
               rb = ca;
            end else begin
               rb = ra;
               cb = ca;
            end
         end
         set_shape(encode_dim(ra), encode_dim(ca), encode_dim(rb), encode_dim(cb), op);
         if ($urandom_range(3) == 0) begin
            write_csr(CSR_IDX_W'($urandom_range(7, int'(CSR_OP_MODE) + 1)),
                      CSR_DATA_W'($urandom));
         end
         runs = $urandom_range(1, 3);
         for (int n = 0; n < runs && queued_count < ITEM_TARGET; n++) begin
            queue_run(ra * ca, rb * cb, 15);
         end
      end

      wait_quiet();
      $display("Covered %0d requests (%0d meant to be dropped) over %0d register shapes.",
               accepted_count, dropped_count, shape_count);
      $display("Checked %0d results from %0d runs, %0d of them dimension errors.",
               checked_count, run_count, error_run_count);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("tb_matrix_add_sub_multiply_unit passed");
      end else begin
         $display("tb_matrix_add_sub_multiply_unit failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mas_pkg.sv
rtl/core/mas_store.sv
rtl/core/mas_engine.sv
rtl/core/matrix_add_sub_multiply_unit.sv
rtl/core/mas_checker.sv
sim/tb_matrix_add_sub_multiply_unit.sv
